FILE: hw/rtl/f3te_pkg.sv
// Shared constants, types and helper functions for the Fourier trajectory evaluator.
package f3te_pkg;

  localparam int unsigned ANGLE_STAGES_DEF = 16;

  localparam int unsigned NUM_REGS = 8;
  localparam int unsigned REG_IDX_W = 3;
  localparam int unsigned REG_W = 16;

  localparam logic [REG_IDX_W-1:0] REG_OFFSET_A0  = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_COS_COEF_1 = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_SIN_COEF_1 = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_COS_COEF_2 = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_SIN_COEF_2 = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_COS_COEF_3 = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_SIN_COEF_3 = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_BASE_FREQ  = 3'd7;

  localparam logic signed [REG_W-1:0] RST_OFFSET_A0  = -16'sd12586;
  localparam logic signed [REG_W-1:0] RST_COS_COEF_1 = 16'sd9372;
  localparam logic signed [REG_W-1:0] RST_SIN_COEF_1 = -16'sd2890;
  localparam logic signed [REG_W-1:0] RST_COS_COEF_2 = 16'sd2238;
  localparam logic signed [REG_W-1:0] RST_SIN_COEF_2 = -16'sd732;
  localparam logic signed [REG_W-1:0] RST_COS_COEF_3 = -16'sd479;
  localparam logic signed [REG_W-1:0] RST_SIN_COEF_3 = 16'sd3383;
  localparam logic [REG_W-1:0]        RST_BASE_FREQ  = 16'd9490;

  // Angle formats, Q.28 radians
  localparam int unsigned RED_W = 51;
  localparam int unsigned RED_CELLS = 19;
  localparam logic [RED_W-1:0] TWO_PI_Q28 = 51'd1686629713;
  localparam logic [32:0] TWO_PI_33  = 33'd1686629713;
  localparam logic [32:0] FOUR_PI_33 = 33'd3373259426;
  localparam logic signed [31:0] TWO_PI_S  = 32'sd1686629713;
  localparam logic signed [31:0] PI_S      = 32'sd843314857;
  localparam logic signed [31:0] HALF_PI_S = 32'sd421657428;

  localparam int unsigned VEC_W = 34;
  localparam logic signed [VEC_W-1:0] CORDIC_GAIN_Q30 = 34'sd652032874;

  typedef struct packed {
    logic signed [VEC_W-1:0] x;
    logic signed [VEC_W-1:0] y;
    logic signed [31:0]      z;
    logic                    flip;
  } rot_t;

  function automatic logic signed [31:0] atan_q28(input int unsigned i);
    logic signed [31:0] r;
    r = '0;
    case (i)
      0: r = 32'sd210828714;
      1: r = 32'sd124459457;
      2: r = 32'sd65760959;
      3: r = 32'sd33381290;
      4: r = 32'sd16755422;
      5: r = 32'sd8385879;
      6: r = 32'sd4193963;
      7: r = 32'sd2097109;
      8: r = 32'sd1048571;
      9: r = 32'sd524287;
      default: begin
        if (i <= 28) r = 32'sd1 <<< (28 - i);
        else r = '0;
      end
    endcase
    return r;
  endfunction

  function automatic logic [31:0] sat32(input logic signed [56:0] v);
    logic [31:0] r;
    if (v > 57'sd2147483647) r = 32'h7fff_ffff;
    else if (v < -57'sd2147483648) r = 32'h8000_0000;
    else r = v[31:0];
    return r;
  endfunction

endpackage

FILE: hw/rtl/f3te_mod_cell.sv
// One conditional-subtract cell of the angle reduction chain.
module f3te_mod_cell #(
  parameter int unsigned SHIFT = 0
) (
  input  logic                         clk_i,
  input  logic                         en_i,
  input  logic [f3te_pkg::RED_W-1:0]   v_i,
  output logic [f3te_pkg::RED_W-1:0]   v_o
);

  localparam logic [f3te_pkg::RED_W-1:0] STEP = f3te_pkg::TWO_PI_Q28 << SHIFT;

  logic [f3te_pkg::RED_W-1:0] v_d, v_q;

  always_comb begin
    v_d = (v_i >= STEP) ? v_i - STEP : v_i;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) v_q <= v_d;
  end

  assign v_o = v_q;

endmodule

FILE: hw/rtl/f3te_cordic_cell.sv
// One rotation-mode CORDIC iteration, registered.
module f3te_cordic_cell #(
  parameter int unsigned STAGE = 0
) (
  input  logic           clk_i,
  input  logic           en_i,
  input  f3te_pkg::rot_t rot_i,
  output f3te_pkg::rot_t rot_o
);

  localparam logic signed [31:0] ATAN = f3te_pkg::atan_q28(STAGE);

  f3te_pkg::rot_t rot_d, rot_q;

  always_comb begin
    rot_d = rot_i;
    if (!rot_i.z[31]) begin
      rot_d.x = rot_i.x - (rot_i.y >>> STAGE);
      rot_d.y = rot_i.y + (rot_i.x >>> STAGE);
      rot_d.z = rot_i.z - ATAN;
    end else begin
      rot_d.x = rot_i.x + (rot_i.y >>> STAGE);
      rot_d.y = rot_i.y - (rot_i.x >>> STAGE);
      rot_d.z = rot_i.z + ATAN;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) rot_q <= rot_d;
  end

  assign rot_o = rot_q;

endmodule

FILE: hw/rtl/fourier3_trajectory_eval.sv
// Top level: pipelined third-order Fourier series position and velocity evaluator.
//
//   channel   direction  handshake                 payload
//   in        to block   in_valid_i / in_stall_o   time_value_i
//   out       from block out_valid_o / out_stall_i position_o, velocity_o
//   cfg       to block   cfg_we_i                  cfg_idx_i, cfg_wdata_i
//
// One word per cycle sustained while no skid word is held; results pass through the
// reduction chain (19 cells) and the three CORDIC chains of ANGLE_STAGES cells.
// Reset loads the force-leg coefficient set and empties the pipeline.
// A stalled result goes to a skid register; the pipeline then holds and
// in_stall_o rises until the skid word is taken.
module fourier3_trajectory_eval #(
  parameter int unsigned ANGLE_STAGES = f3te_pkg::ANGLE_STAGES_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic signed [31:0]                time_value_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [31:0]                position_o,
  output logic signed [31:0]                velocity_o,
  input  logic                              cfg_we_i,
  input  logic [f3te_pkg::REG_IDX_W-1:0]    cfg_idx_i,
  input  logic [f3te_pkg::REG_W-1:0]        cfg_wdata_i
);

  localparam int unsigned LAT = ANGLE_STAGES + 29;
  localparam int unsigned VW = f3te_pkg::VEC_W;
  localparam int unsigned RW = f3te_pkg::RED_W;
  localparam logic [RW-1:0] RED_OFS = f3te_pkg::TWO_PI_Q28 << (f3te_pkg::RED_CELLS - 1);

  // configuration registers
  logic signed [15:0] a0_q;
  logic signed [15:0] ak_q [3];
  logic signed [15:0] bk_q [3];
  logic [15:0]        w_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a0_q    <= f3te_pkg::RST_OFFSET_A0;
      ak_q[0] <= f3te_pkg::RST_COS_COEF_1;
      bk_q[0] <= f3te_pkg::RST_SIN_COEF_1;
      ak_q[1] <= f3te_pkg::RST_COS_COEF_2;
      bk_q[1] <= f3te_pkg::RST_SIN_COEF_2;
      ak_q[2] <= f3te_pkg::RST_COS_COEF_3;
      bk_q[2] <= f3te_pkg::RST_SIN_COEF_3;
      w_q     <= f3te_pkg::RST_BASE_FREQ;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        f3te_pkg::REG_OFFSET_A0:  a0_q    <= cfg_wdata_i;
        f3te_pkg::REG_COS_COEF_1: ak_q[0] <= cfg_wdata_i;
        f3te_pkg::REG_SIN_COEF_1: bk_q[0] <= cfg_wdata_i;
        f3te_pkg::REG_COS_COEF_2: ak_q[1] <= cfg_wdata_i;
        f3te_pkg::REG_SIN_COEF_2: bk_q[1] <= cfg_wdata_i;
        f3te_pkg::REG_COS_COEF_3: ak_q[2] <= cfg_wdata_i;
        f3te_pkg::REG_SIN_COEF_3: bk_q[2] <= cfg_wdata_i;
        f3te_pkg::REG_BASE_FREQ:  w_q     <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // flow control
  logic           skid_valid_q;
  logic           en;
  logic [LAT-1:0] vld_q;
  logic           tail_valid;
  logic [31:0]    pos_t_q, vel_t_q;
  logic [31:0]    skid_pos_q, skid_vel_q;
  logic           out_valid_q;
  logic [31:0]    out_pos_q, out_vel_q;

  assign en         = !skid_valid_q;
  assign in_stall_o = skid_valid_q;
  assign tail_valid = vld_q[LAT-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[LAT-2:0], in_valid_i};
    end
  end

  // theta = w * x, then bias to a non-negative value
  logic signed [48:0] theta_q;
  logic [RW-1:0]      red_w [f3te_pkg::RED_CELLS+1];
  logic [RW-1:0]      bias_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      theta_q <= $signed({1'b0, w_q}) * time_value_i;
      bias_q  <= RW'(theta_q) + RED_OFS;
    end
  end

  assign red_w[0] = bias_q;

  for (genvar j = 0; j < f3te_pkg::RED_CELLS; j++) begin : g_red
    f3te_mod_cell #(
      .SHIFT(f3te_pkg::RED_CELLS - 1 - j)
    ) u_cell (
      .clk_i(clk_i),
      .en_i (en),
      .v_i  (red_w[j]),
      .v_o  (red_w[j+1])
    );
  end

  // angles k*r mod 2*pi
  logic [30:0] r;
  logic [32:0] r2, r3;
  logic [30:0] ang_q [3];

  assign r  = red_w[f3te_pkg::RED_CELLS][30:0];
  assign r2 = {1'b0, r, 1'b0};
  assign r3 = r2 + 33'(r);

  always_ff @(posedge clk_i) begin
    if (en) begin
      ang_q[0] <= r;
      ang_q[1] <= (r2 >= f3te_pkg::TWO_PI_33) ? 31'(r2 - f3te_pkg::TWO_PI_33) : r2[30:0];
      if (r3 >= f3te_pkg::FOUR_PI_33) ang_q[2] <= 31'(r3 - f3te_pkg::FOUR_PI_33);
      else if (r3 >= f3te_pkg::TWO_PI_33) ang_q[2] <= 31'(r3 - f3te_pkg::TWO_PI_33);
      else ang_q[2] <= r3[30:0];
    end
  end

  // fold into [-pi/2, pi/2] and run the three CORDIC chains
  f3te_pkg::rot_t rot_w [3][ANGLE_STAGES+1];
  f3te_pkg::rot_t fold_d [3];
  f3te_pkg::rot_t fold_q [3];
  logic signed [VW-1:0] c_q [3];
  logic signed [VW-1:0] s_q [3];

  for (genvar k = 0; k < 3; k++) begin : g_lane
    logic signed [31:0] t;

    always_comb begin
      t = $signed({1'b0, ang_q[k]});
      if (t >= f3te_pkg::PI_S) t = t - f3te_pkg::TWO_PI_S;
      fold_d[k].x    = f3te_pkg::CORDIC_GAIN_Q30;
      fold_d[k].y    = '0;
      fold_d[k].z    = t;
      fold_d[k].flip = 1'b0;
      if (t > f3te_pkg::HALF_PI_S) begin
        fold_d[k].z    = t - f3te_pkg::PI_S;
        fold_d[k].flip = 1'b1;
      end else if (t < -f3te_pkg::HALF_PI_S) begin
        fold_d[k].z    = t + f3te_pkg::PI_S;
        fold_d[k].flip = 1'b1;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) fold_q[k] <= fold_d[k];
    end

    assign rot_w[k][0] = fold_q[k];

    for (genvar i = 0; i < ANGLE_STAGES; i++) begin : g_cell
      f3te_cordic_cell #(
        .STAGE(i)
      ) u_cell (
        .clk_i(clk_i),
        .en_i (en),
        .rot_i(rot_w[k][i]),
        .rot_o(rot_w[k][i+1])
      );
    end

    // undo the pi move
    always_ff @(posedge clk_i) begin
      if (en) begin
        c_q[k] <= rot_w[k][ANGLE_STAGES].flip ? -rot_w[k][ANGLE_STAGES].x
                                              : rot_w[k][ANGLE_STAGES].x;
        s_q[k] <= rot_w[k][ANGLE_STAGES].flip ? -rot_w[k][ANGLE_STAGES].y
                                              : rot_w[k][ANGLE_STAGES].y;
      end
    end
  end

  // products, sums, rounding, velocity scale
  logic signed [49:0] ac_q [3];
  logic signed [49:0] bs_q [3];
  logic signed [49:0] bc_q [3];
  logic signed [49:0] as_q [3];
  logic signed [55:0] pos_sum_q, inner_q;
  logic signed [55:0] pos_sum_d, inner_d;
  logic signed [31:0] pos_r_q, pos_m_q;
  logic signed [39:0] inner_r_q;
  logic signed [56:0] vel_p_q;
  logic signed [55:0] pos_rnd;
  logic signed [55:0] inner_rnd;
  logic signed [56:0] vel_rnd;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        ac_q[k] <= ak_q[k] * c_q[k];
        bs_q[k] <= bk_q[k] * s_q[k];
        bc_q[k] <= bk_q[k] * c_q[k];
        as_q[k] <= ak_q[k] * s_q[k];
      end
    end
  end

  always_comb begin
    pos_sum_d = 56'(a0_q) <<< 30;
    inner_d   = '0;
    for (int k = 0; k < 3; k++) begin
      pos_sum_d = pos_sum_d + 56'(ac_q[k]) + 56'(bs_q[k]);
      inner_d   = inner_d + (56'(bc_q[k]) - 56'(as_q[k])) * 56'(k + 1);
    end
  end

  assign pos_rnd   = (pos_sum_q + 56'sd134217728) >>> 28;
  assign inner_rnd = (inner_q + 56'sd32768) >>> 16;
  assign vel_rnd   = (vel_p_q + 57'sd8388608) >>> 24;

  always_ff @(posedge clk_i) begin
    if (en) begin
      pos_sum_q <= pos_sum_d;
      inner_q   <= inner_d;
      pos_r_q   <= f3te_pkg::sat32(57'(pos_rnd));
      inner_r_q <= inner_rnd[39:0];
      pos_m_q   <= pos_r_q;
      vel_p_q   <= 57'(inner_r_q * $signed({1'b0, w_q}));
      pos_t_q   <= pos_m_q;
      vel_t_q   <= f3te_pkg::sat32(vel_rnd);
    end
  end

  // output register with skid stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (!out_valid_q || !out_stall_i) begin
        if (skid_valid_q) begin
          out_valid_q  <= 1'b1;
          skid_valid_q <= 1'b0;
        end else begin
          out_valid_q <= en && tail_valid;
        end
      end else if (en && tail_valid) begin
        skid_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || !out_stall_i) begin
      if (skid_valid_q) begin
        out_pos_q <= skid_pos_q;
        out_vel_q <= skid_vel_q;
      end else if (en && tail_valid) begin
        out_pos_q <= pos_t_q;
        out_vel_q <= vel_t_q;
      end
    end else if (en && tail_valid) begin
      skid_pos_q <= pos_t_q;
      skid_vel_q <= vel_t_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign position_o  = out_pos_q;
  assign velocity_o  = out_vel_q;

  // a held skid word always has a word ahead of it at the output
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q) else $error("skid word without output word");

  // a finished word meeting a stalled output lands in the skid stage
  a_skid_catch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en && tail_valid && out_valid_q && out_stall_i) |=> skid_valid_q)
    else $error("finished word lost under stall");

  // the skid drains as soon as the output moves
  a_skid_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skid_valid_q && !out_stall_i) |=> (!skid_valid_q && out_valid_q))
    else $error("skid word not drained");

endmodule
